// File: rtl/core/source_lexer_keyword_tokenizer_defines.svh
`ifndef SOURCE_LEXER_KEYWORD_TOKENIZER_DEFINES_SVH
`define SOURCE_LEXER_KEYWORD_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SLKT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SLKT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/slkt_pkg.sv
`default_nettype none

package slkt_pkg;

  localparam int unsigned KwCount  = 5;
  localparam int unsigned KwSlots  = 8;
  localparam int unsigned MaxRes   = 3;

  typedef enum logic [1:0] {
    KindByte  = 2'd0,
    KindClose = 2'd1,
    KindError = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ClsKeyword = 2'd0,
    ClsIdent   = 2'd1,
    ClsNumber  = 2'd2,
    ClsSymbol  = 2'd3
  } class_e;

  localparam logic [2:0] KwNone = 3'd0;
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] ChUnderscore = 8'h5F;

  typedef struct packed {
    kind_e      kind;
    class_e     cls;
    logic [7:0] ch;
    logic [2:0] kw;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]               cnt;
    result_t [MaxRes-1:0]     res;
  } burst_t;

  // Keyword spelling, padded with zeros to a power-of-two depth
  localparam logic [KwCount-1:0][KwSlots-1:0][7:0] KwText = '{
    '{8'h00, 8'h00, 8'h6E, 8'h72, 8'h75, 8'h74, 8'h65, 8'h72},  // return
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h6E, 8'h66},  // fn
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h74, 8'h61, 8'h6D},  // mat
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h63, 8'h65, 8'h76},  // vec
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h6D, 8'h75, 8'h6E}   // num
  };

  localparam logic [KwCount-1:0][2:0] KwLen = '{3'd6, 3'd2, 3'd3, 3'd3, 3'd3};

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return c == 8'h3D || c == 8'h2C || c == 8'h3B || c == 8'h28 || c == 8'h29 ||
           c == 8'h5B || c == 8'h5D || c == 8'h7B || c == 8'h7D || c == 8'h2B ||
           c == 8'h2D || c == 8'h2A || c == 8'h2F || c == 8'h5E;
  endfunction

  // Keywords whose character at position pos is c
  function automatic logic [KwCount-1:0] kw_match(input logic [2:0] pos,
                                                  input logic [7:0] c);
    logic [KwCount-1:0] m;
    m = '0;
    for (int i = 0; i < KwCount; i++) begin
      m[i] = (pos < KwLen[i]) && (KwText[i][pos] == c);
    end
    return m;
  endfunction

  // First live keyword of exactly this length, numbered from one
  function automatic logic [2:0] kw_close(input logic [KwCount-1:0] alive,
                                          input logic [2:0] len);
    logic [2:0] idx;
    idx = KwNone;
    for (int i = KwCount - 1; i >= 0; i--) begin
      if (alive[i] && len == KwLen[i]) begin
        idx = 3'(i + 1);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/slkt_stream_if.sv
`default_nettype none

interface slkt_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_code;

  modport source (output valid, req_type, char_code, input ready);
  modport sink   (input valid, req_type, char_code, output ready);
endinterface

interface slkt_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [1:0] token_class;
  logic [7:0] char_code_out;
  logic [2:0] keyword_index;
  logic       last_in_run;

  modport source (output valid, out_kind, token_class, char_code_out, keyword_index,
                  last_in_run, input ready);
  modport sink   (input valid, out_kind, token_class, char_code_out, keyword_index,
                  last_in_run, output ready);
endinterface

`default_nettype wire

// File: rtl/core/source_lexer_keyword_tokenizer.sv
// The first result of a word is offered in the cycle after the word is accepted.
// Throughput: one word per cycle while each word gives at most one result and the output
// is not stalled; a word that gives more results holds off the next word until its last result leaves.
// Reset (rst_ni low, asynchronous) returns the scanner to idle with no open token,
// clears the output queue and leaves a halted scanner running again.
`default_nettype none

module source_lexer_keyword_tokenizer import slkt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  slkt_req_if.sink   req_i,
  slkt_res_if.source res_o
);

  burst_t  burst;
  result_t res;
  logic    in_ready;
  logic    accept;

  assign accept      = req_i.valid && in_ready;
  assign req_i.ready = in_ready;

  slkt_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (req_i.req_type),
    .char_i     (req_i.char_code),
    .burst_o    (burst)
  );

  slkt_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .burst_i     (burst),
    .out_ready_i (res_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (res_o.valid),
    .res_o       (res)
  );

  assign res_o.out_kind      = res.kind;
  assign res_o.token_class   = res.cls;
  assign res_o.char_code_out = res.ch;
  assign res_o.keyword_index = res.kw;
  assign res_o.last_in_run   = res.last;

endmodule

`default_nettype wire

// File: rtl/core/slkt_core.sv
`default_nettype none

module slkt_core import slkt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       req_type_i,
  input  logic [7:0] char_i,
  output burst_t     burst_o
);

  typedef enum logic [1:0] {
    ModeIdle = 2'd0,
    ModeWord = 2'd1,
    ModeNum  = 2'd2,
    ModeHalt = 2'd3
  } mode_e;

  mode_e              mode_q, mode_d;
  logic [2:0]         len_q, len_d;
  logic [KwCount-1:0] alive_q, alive_d;

  always_comb begin
    logic [1:0] n;
    logic       letter;
    logic       digit;
    logic       open_tok;
    logic [2:0] close_kw;
    class_e     close_cls;

    mode_d  = mode_q;
    len_d   = len_q;
    alive_d = alive_q;
    burst_o = '0;
    n       = 2'd0;

    letter   = is_letter(char_i);
    digit    = is_digit(char_i);
    open_tok = (mode_q == ModeWord) || (mode_q == ModeNum);

    close_kw = (mode_q == ModeWord) ? kw_close(alive_q, len_q) : KwNone;
    if (mode_q == ModeWord) begin
      close_cls = (close_kw != KwNone) ? ClsKeyword : ClsIdent;
    end else begin
      close_cls = ClsNumber;
    end

    if (mode_q == ModeHalt) begin
      // drop everything until reset
    end else if (req_type_i) begin
      if (open_tok) begin
        burst_o.res[n] = '{kind: KindClose, cls: close_cls, ch: 8'h00, kw: close_kw,
                           last: 1'b0};
        n       = n + 2'd1;
        mode_d  = ModeIdle;
        len_d   = 3'd0;
        alive_d = '1;
      end
    end else if (mode_q == ModeWord && (letter || digit || char_i == ChUnderscore)) begin
      alive_d = alive_q & kw_match(len_q, char_i);
      len_d   = (len_q != 3'd7) ? len_q + 3'd1 : len_q;
      burst_o.res[n] = '{kind: KindByte, cls: ClsIdent, ch: char_i, kw: KwNone, last: 1'b0};
      n = n + 2'd1;
    end else if (mode_q == ModeNum && digit) begin
      burst_o.res[n] = '{kind: KindByte, cls: ClsNumber, ch: char_i, kw: KwNone, last: 1'b0};
      n = n + 2'd1;
    end else begin
      // close the open token first, then treat the word as if idle
      if (open_tok) begin
        burst_o.res[n] = '{kind: KindClose, cls: close_cls, ch: 8'h00, kw: close_kw,
                           last: 1'b0};
        n       = n + 2'd1;
        mode_d  = ModeIdle;
        len_d   = 3'd0;
        alive_d = '1;
      end
      if (letter) begin
        mode_d  = ModeWord;
        len_d   = 3'd1;
        alive_d = kw_match(3'd0, char_i);
        burst_o.res[n] = '{kind: KindByte, cls: ClsIdent, ch: char_i, kw: KwNone,
                           last: 1'b0};
        n = n + 2'd1;
      end else if (digit) begin
        mode_d  = ModeNum;
        len_d   = 3'd0;
        alive_d = '1;
        burst_o.res[n] = '{kind: KindByte, cls: ClsNumber, ch: char_i, kw: KwNone,
                           last: 1'b0};
        n = n + 2'd1;
      end else if (is_symbol(char_i)) begin
        burst_o.res[n] = '{kind: KindByte, cls: ClsSymbol, ch: char_i, kw: KwNone,
                           last: 1'b0};
        n = n + 2'd1;
        burst_o.res[n] = '{kind: KindClose, cls: ClsSymbol, ch: 8'h00, kw: KwNone,
                           last: 1'b0};
        n = n + 2'd1;
      end else if (char_i != ChSpace) begin
        burst_o.res[n] = '{kind: KindError, cls: ClsKeyword, ch: char_i, kw: KwNone,
                           last: 1'b0};
        n      = n + 2'd1;
        mode_d = ModeHalt;
      end
    end

    for (int i = 0; i < MaxRes; i++) begin
      burst_o.res[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
    end
    burst_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      len_q   <= 3'd0;
      alive_q <= '1;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      len_q   <= len_d;
      alive_q <= alive_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/slkt_serializer.sv
`default_nettype none

module slkt_serializer import slkt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  burst_t  burst_i,
  input  logic    out_ready_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  output result_t res_o
);

  logic [1:0]           rem_q, rem_d;
  result_t [MaxRes-1:0] slot_q, slot_d;
  logic                 pop;
  logic                 load;

  assign pop         = (rem_q != 2'd0) && out_ready_i;
  assign load        = accept_i && (burst_i.cnt != 2'd0);
  // take a new word when the queue is empty or its last queued result leaves this cycle
  assign in_ready_o  = (rem_q == 2'd0) || ((rem_q == 2'd1) && out_ready_i);
  assign out_valid_o = (rem_q != 2'd0);
  assign res_o       = slot_q[0];

  always_comb begin
    rem_d  = rem_q;
    slot_d = slot_q;
    if (load) begin
      rem_d  = burst_i.cnt;
      slot_d = burst_i.res;
    end else if (pop) begin
      rem_d = rem_q - 2'd1;
      for (int i = 0; i < MaxRes - 1; i++) begin
        slot_d[i] = slot_q[i + 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

`default_nettype wire

// File: rtl/core/slkt_checker.sv
`default_nettype none
`include "source_lexer_keyword_tokenizer_defines.svh"

module slkt_checker import slkt_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_kind_i,
  input logic [1:0] token_class_i,
  input logic [2:0] keyword_index_i,
  input logic       last_in_run_i
);

  // hold a stalled result
  `SLKT_ASSERT_NEXT(a_valid_holds, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")

  // a keyword number only rides on the close of a keyword
  `SLKT_ASSERT_NOW(a_kw_on_close, out_valid_i && keyword_index_i != KwNone, out_kind_i == KindClose && token_class_i == ClsKeyword, "keyword number outside a keyword close")

  // an error always ends its run
  `SLKT_ASSERT_NOW(a_err_last, out_valid_i && out_kind_i == KindError, last_in_run_i, "error result not last in run")

  // the scanner stays silent after an error until reset
  `SLKT_ASSERT_NEXT(a_halt_silent, out_valid_i && out_ready_i && out_kind_i == KindError, !out_valid_i, "result after error")

endmodule

bind source_lexer_keyword_tokenizer slkt_checker u_slkt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .out_kind_i      (res_o.out_kind),
  .token_class_i   (res_o.token_class),
  .keyword_index_i (res_o.keyword_index),
  .last_in_run_i   (res_o.last_in_run)
);

`default_nettype wire
